// ===== rtl/ifbs_pkg.sv =====
// ----------------------------------------------------------------------------
// ifbs_pkg
// Shared types, constants and helpers for the information frame byte stuffer.
// ----------------------------------------------------------------------------
package ifbs_pkg;

	localparam logic [7:0] FRAME_FLAG   = 8'h7E;
	localparam logic [7:0] ESCAPE_BYTE  = 8'h7D;
	localparam logic [7:0] FLAG_SUBST   = 8'h5E;
	localparam logic [7:0] ESCAPE_SUBST = 8'h5D;

	// Item opcodes.
	localparam logic OP_DATA = 1'b0;
	localparam logic OP_ACK  = 1'b1;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_ADDRESS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CTRL_ZERO = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CTRL_ONE  = 2'd2;

	localparam logic [7:0] ADDRESS_RESET   = 8'd3;
	localparam logic [7:0] CTRL_ZERO_RESET = 8'd0;
	localparam logic [7:0] CTRL_ONE_RESET  = 8'd64;

	// Default depth of the queue between the front and back parts.
	localparam int QUEUE_DEPTH = 2;

	// One classified payload request, everything the back part needs.
	typedef struct packed {
		logic       hdr;   // open a frame: flag, address, control, header check
		logic [7:0] addr;
		logic [7:0] ctrl;
		logic [7:0] data;
		logic       last;  // close the frame: check, closing flag
		logic [7:0] chk;   // payload check including this byte
	} frame_cmd_t;

	// Output steps of one request.
	typedef enum logic [8:0] {
		ST_FLAG  = 9'b000000001,
		ST_ADDR  = 9'b000000010,
		ST_CTRL  = 9'b000000100,
		ST_HCHK  = 9'b000001000,
		ST_DATA  = 9'b000010000,
		ST_DSUB  = 9'b000100000,
		ST_CHK   = 9'b001000000,
		ST_CSUB  = 9'b010000000,
		ST_CLOSE = 9'b100000000
	} emit_step_t;

	function automatic logic needs_escape(input logic [7:0] b);
		return (b == FRAME_FLAG) || (b == ESCAPE_BYTE);
	endfunction

	function automatic logic [7:0] escape_subst(input logic [7:0] b);
		return (b == FRAME_FLAG) ? FLAG_SUBST : ESCAPE_SUBST;
	endfunction

endpackage

// ===== rtl/ifbs_item_if.sv =====
// ----------------------------------------------------------------------------
// ifbs_item_if
// Input channel: payload bytes and acknowledgments.
// ----------------------------------------------------------------------------
interface ifbs_item_if;
	logic       valid;
	logic       ready;
	logic       op;
	logic [7:0] data_byte;
	logic       last;

	modport source (output valid, output op, output data_byte, output last, input ready);
	modport sink (input valid, input op, input data_byte, input last, output ready);
endinterface

// ===== rtl/ifbs_result_if.sv =====
// ----------------------------------------------------------------------------
// ifbs_result_if
// Output channel: one framed, stuffed byte per request.
// ----------------------------------------------------------------------------
interface ifbs_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       burst_end;
	logic       frame_end;

	modport source (output valid, output out_byte, output burst_end, output frame_end,
		input ready);
	modport sink (input valid, input out_byte, input burst_end, input frame_end,
		output ready);
endinterface

// ===== rtl/ifbs_cfg_if.sv =====
// ----------------------------------------------------------------------------
// ifbs_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface ifbs_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] index;
	logic [7:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/ifbs_front.sv =====
// ----------------------------------------------------------------------------
// ifbs_front
// Accepts items, tracks frame state and turns each payload byte into a request.
// ----------------------------------------------------------------------------
module ifbs_front (
	input  logic               clk,
	input  logic               arst_n,
	ifbs_item_if.sink          item,
	ifbs_cfg_if.sink           cfg,
	input  logic               q_full,
	output logic               q_push,
	output ifbs_pkg::frame_cmd_t q_cmd
);
	import ifbs_pkg::*;

	logic [7:0] address_q;
	logic [7:0] ctrl_zero_q;
	logic [7:0] ctrl_one_q;
	logic       in_frame_q;
	logic [7:0] chk_q;
	logic       seq_q;
	logic       accept;
	logic [7:0] chk_next;

	assign cfg.ready  = 1'b1;
	assign item.ready = !q_full;
	assign accept     = item.valid && item.ready;
	assign q_push     = accept && (item.op == OP_DATA);

	assign chk_next = (in_frame_q ? chk_q : 8'h00) ^ item.data_byte;

	always_comb begin
		q_cmd.hdr  = !in_frame_q;
		q_cmd.addr = address_q;
		q_cmd.ctrl = seq_q ? ctrl_one_q : ctrl_zero_q;
		q_cmd.data = item.data_byte;
		q_cmd.last = item.last;
		q_cmd.chk  = chk_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			address_q   <= ADDRESS_RESET;
			ctrl_zero_q <= CTRL_ZERO_RESET;
			ctrl_one_q  <= CTRL_ONE_RESET;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				CFG_ADDRESS:   address_q   <= cfg.data;
				CFG_CTRL_ZERO: ctrl_zero_q <= cfg.data;
				CFG_CTRL_ONE:  ctrl_one_q  <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			chk_q      <= 8'h00;
			seq_q      <= 1'b0;
		end else if (accept) begin
			if (item.op == OP_ACK) begin
				seq_q <= !seq_q;
			end else if (item.last) begin
				in_frame_q <= 1'b0;
				chk_q      <= 8'h00;
			end else begin
				in_frame_q <= 1'b1;
				chk_q      <= chk_next;
			end
		end
	end

endmodule

// ===== rtl/ifbs_queue.sv =====
// ----------------------------------------------------------------------------
// ifbs_queue
// Small first-in first-out queue of frame requests.
// ----------------------------------------------------------------------------
module ifbs_queue #(
	parameter int Depth = ifbs_pkg::QUEUE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  ifbs_pkg::frame_cmd_t push_cmd,
	output logic                 full,
	input  logic                 pop,
	output logic                 head_valid,
	output ifbs_pkg::frame_cmd_t head_cmd
);
	import ifbs_pkg::*;

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
	localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

	frame_cmd_t      mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            do_push;
	logic            do_pop;

	assign full       = (count_q == FullCnt);
	assign head_valid = (count_q != '0);
	assign head_cmd   = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/ifbs_back.sv =====
// ----------------------------------------------------------------------------
// ifbs_back
// Steps through one request at a time and sends one output byte per cycle while the output side is ready.
// ----------------------------------------------------------------------------
module ifbs_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 head_valid,
	input  ifbs_pkg::frame_cmd_t head_cmd,
	output logic                 pop,
	ifbs_result_if.source        result
);
	import ifbs_pkg::*;

	emit_step_t step_q;
	logic       started_q;
	emit_step_t step_cur;
	emit_step_t step_nxt;
	logic [7:0] byte_cur;
	logic       is_close;
	logic       req_done;
	logic       advance;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       burst_end_q;
	logic       frame_end_q;

	// A fresh request starts at the header or straight at its payload byte.
	assign step_cur = started_q ? step_q : (head_cmd.hdr ? ST_FLAG : ST_DATA);

	always_comb begin
		byte_cur = FRAME_FLAG;
		step_nxt = ST_FLAG;
		is_close = 1'b0;
		req_done = 1'b0;
		unique case (step_cur)
			ST_FLAG: begin
				byte_cur = FRAME_FLAG;
				step_nxt = ST_ADDR;
			end
			ST_ADDR: begin
				byte_cur = head_cmd.addr;
				step_nxt = ST_CTRL;
			end
			ST_CTRL: begin
				byte_cur = head_cmd.ctrl;
				step_nxt = ST_HCHK;
			end
			ST_HCHK: begin
				byte_cur = head_cmd.addr ^ head_cmd.ctrl;
				step_nxt = ST_DATA;
			end
			ST_DATA: begin
				if (needs_escape(head_cmd.data)) begin
					byte_cur = ESCAPE_BYTE;
					step_nxt = ST_DSUB;
				end else begin
					byte_cur = head_cmd.data;
					step_nxt = ST_CHK;
					req_done = !head_cmd.last;
				end
			end
			ST_DSUB: begin
				byte_cur = escape_subst(head_cmd.data);
				step_nxt = ST_CHK;
				req_done = !head_cmd.last;
			end
			ST_CHK: begin
				if (needs_escape(head_cmd.chk)) begin
					byte_cur = ESCAPE_BYTE;
					step_nxt = ST_CSUB;
				end else begin
					byte_cur = head_cmd.chk;
					step_nxt = ST_CLOSE;
				end
			end
			ST_CSUB: begin
				byte_cur = escape_subst(head_cmd.chk);
				step_nxt = ST_CLOSE;
			end
			ST_CLOSE: begin
				byte_cur = FRAME_FLAG;
				is_close = 1'b1;
				req_done = 1'b1;
			end
			default: begin
				req_done = 1'b1;
			end
		endcase
	end

	assign advance = head_valid && (!out_valid_q || result.ready);
	assign pop     = advance && req_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q    <= ST_FLAG;
			started_q <= 1'b0;
		end else if (advance) begin
			started_q <= !req_done;
			step_q    <= step_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_byte_q  <= byte_cur;
			burst_end_q <= req_done;
			frame_end_q <= is_close;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.out_byte  = out_byte_q;
	assign result.burst_end = burst_end_q;
	assign result.frame_end = frame_end_q;

endmodule

// ===== rtl/info_frame_byte_stuffer.sv =====
// ----------------------------------------------------------------------------
// info_frame_byte_stuffer
// Builds information frames with byte stuffing from a stream of payload bytes.
// ----------------------------------------------------------------------------
// The block sends one output byte per clock cycle while the result side is
// ready. An acknowledgment causes no output byte, a plain payload byte
// causes one, an escaped one two, the first byte of a frame adds four header
// bytes and the last byte adds two or three for the check and closing flag.
// The output sequencer in the back part produces these bytes; the front part
// takes a new item in every cycle in which the request queue has room, so it
// keeps working while the back part is still sending an earlier frame.
// Configuration writes are always accepted and reach the next frame header.
// ----------------------------------------------------------------------------
module info_frame_byte_stuffer #(
	parameter int QueueDepth = ifbs_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	ifbs_item_if.sink     item,
	ifbs_result_if.source result,
	ifbs_cfg_if.sink      cfg
);
	import ifbs_pkg::*;

	// Requests from the front part, one per payload byte, waiting for the
	// back part. Acknowledgments only touch the sequence bit and never
	// enter the queue.
	frame_cmd_t push_cmd;
	frame_cmd_t head_cmd;
	logic       push;
	logic       full;
	logic       pop;
	logic       head_valid;

	// The front part classifies each item: it decides whether a header is
	// due, picks the control byte for the current sequence bit and keeps the
	// running payload check, so every request is complete in itself.
	ifbs_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cfg    (cfg),
		.q_full (full),
		.q_push (push),
		.q_cmd  (push_cmd)
	);

	// The queue lets the two parts stall independently.
	ifbs_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	// The back part walks a request through its bytes, escaping the payload
	// byte and the payload check where needed, and holds each byte in an
	// output register until the consumer takes it.
	ifbs_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop),
		.result     (result)
	);

endmodule

// ===== tb/info_frame_byte_stuffer_tb.sv =====
// ----------------------------------------------------------------------------
// info_frame_byte_stuffer_tb
// Self-checking bench for the information frame byte stuffer. A scoreboard
// class predicts the framed, stuffed byte stream from every accepted request
// and compares each byte that leaves the block, field by field. Directed
// frames cover the escapes, the header corner cases and acknowledgments, then
// random frames run under several register settings with random stalls.
// ----------------------------------------------------------------------------
module info_frame_byte_stuffer_tb;
	import ifbs_pkg::*;

	// One byte of the framed output stream as the block should present it.
	typedef struct {
		logic [7:0] out_byte;
		logic       burst_end;
		logic       frame_end;
	} framed_byte_t;

	// Frame predictor and checker. It keeps its own copy of the registers,
	// of the open-frame flag, the running payload check and the sequence bit.
	class frame_scoreboard;
		framed_byte_t expected_bytes[$];
		logic [7:0]   address_reg;
		logic [7:0]   ctrl_zero_reg;
		logic [7:0]   ctrl_one_reg;
		logic         frame_open;
		logic [7:0]   running_check;
		logic         seq_bit;
		int           mismatches;

		function new();
			address_reg   = ADDRESS_RESET;
			ctrl_zero_reg = CTRL_ZERO_RESET;
			ctrl_one_reg  = CTRL_ONE_RESET;
			frame_open    = 1'b0;
			running_check = 8'h00;
			seq_bit       = 1'b0;
			mismatches    = 0;
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [7:0] value);
			case (idx)
				CFG_ADDRESS: begin
					address_reg = value;
				end
				CFG_CTRL_ZERO: begin
					ctrl_zero_reg = value;
				end
				CFG_CTRL_ONE: begin
					ctrl_one_reg = value;
				end
				default: begin
				end
			endcase
		endfunction

		function void push_byte(logic [7:0] b, logic closing);
			framed_byte_t e;
			e.out_byte  = b;
			e.burst_end = 1'b0;
			e.frame_end = closing;
			expected_bytes.push_back(e);
		endfunction

		function void push_stuffed(logic [7:0] b);
			if (b == FRAME_FLAG) begin
				push_byte(ESCAPE_BYTE, 1'b0);
				push_byte(FLAG_SUBST, 1'b0);
			end else if (b == ESCAPE_BYTE) begin
				push_byte(ESCAPE_BYTE, 1'b0);
				push_byte(ESCAPE_SUBST, 1'b0);
			end else begin
				push_byte(b, 1'b0);
			end
		endfunction

		// Called once for every accepted input request.
		function void note_request(logic op, logic [7:0] data, logic last);
			logic [7:0]   ctrl;
			framed_byte_t tail;
			if (op == OP_ACK) begin
				seq_bit = ~seq_bit;
				return;
			end
			if (!frame_open) begin
				ctrl = seq_bit ? ctrl_one_reg : ctrl_zero_reg;
				push_byte(FRAME_FLAG, 1'b0);
				push_byte(address_reg, 1'b0);
				push_byte(ctrl, 1'b0);
				push_byte(address_reg ^ ctrl, 1'b0);
				frame_open    = 1'b1;
				running_check = 8'h00;
			end
			push_stuffed(data);
			running_check = running_check ^ data;
			if (last) begin
				push_stuffed(running_check);
				push_byte(FRAME_FLAG, 1'b1);
				frame_open    = 1'b0;
				running_check = 8'h00;
			end
			tail = expected_bytes.pop_back();
			tail.burst_end = 1'b1;
			expected_bytes.push_back(tail);
		endfunction

		// Called once for every accepted output request.
		function void check_result(logic [7:0] b, logic be, logic fe);
			framed_byte_t e;
			if (expected_bytes.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected output byte %02h burst_end %0b frame_end %0b",
						b, be, fe);
				mismatches++;
				return;
			end
			e = expected_bytes.pop_front();
			if (e.out_byte !== b || e.burst_end !== be || e.frame_end !== fe) begin
				if (mismatches < 10)
					$display("output mismatch: expected %02h %0b %0b, got %02h %0b %0b",
						e.out_byte, e.burst_end, e.frame_end, b, be, fe);
				mismatches++;
			end
		endfunction

		function int pending();
			return expected_bytes.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	ifbs_item_if   item_if();
	ifbs_result_if result_if();
	ifbs_cfg_if    cfg_if();

	info_frame_byte_stuffer uut (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (item_if),
		.result(result_if),
		.cfg   (cfg_if)
	);

	frame_scoreboard sb;

	// Receiver controls. The stimulus may ask for one long hold-off, which the
	// receiver process counts down itself; otherwise it stalls in random bursts
	// whose likelihood per cycle is given in percent.
	int rx_hold_cycles = 0;
	int rx_stall_pct   = 0;
	int rx_burst_left  = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Receiver: ready is driven only at the falling edge, and exactly once per
	// edge, so the block always sees a stable value at the rising edge.
	initial begin
		result_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_cycles > 0) begin
				rx_hold_cycles--;
				result_if.ready <= 1'b0;
			end else if (rx_burst_left > 0) begin
				rx_burst_left--;
				result_if.ready <= 1'b0;
			end else if ($urandom_range(0, 99) < rx_stall_pct) begin
				rx_burst_left = $urandom_range(1, 18) - 1;
				result_if.ready <= 1'b0;
			end else begin
				result_if.ready <= 1'b1;
			end
		end
	end

	// Every output request that completes at a rising edge is checked against
	// the oldest expected byte.
	always @(posedge clk) begin
		if (arst_n && result_if.valid && result_if.ready)
			sb.check_result(result_if.out_byte, result_if.burst_end, result_if.frame_end);
	end

	// Biased byte source: the flag and the escape byte turn up far more often
	// than they would by chance, so stuffing is exercised all the time.
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 9))
			0: return FRAME_FLAG;
			1: return ESCAPE_BYTE;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Offers one input request from a falling edge and returns at the falling
	// edge after it was taken. Valid is left high, so back-to-back requests
	// never drop it in between.
	task automatic send_item(logic op, logic [7:0] data, logic last);
		item_if.valid     <= 1'b1;
		item_if.op        <= op;
		item_if.data_byte <= data;
		item_if.last      <= last;
		do @(posedge clk); while (!item_if.ready);
		sb.note_request(op, data, last);
		@(negedge clk);
	endtask

	task automatic idle_gap(int cycles);
		item_if.valid <= 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	// Sender pauses until every expected byte has come out.
	task automatic drain_results();
		item_if.valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
	endtask

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [7:0] value);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= value;
		do @(posedge clk); while (!cfg_if.ready);
		sb.set_register(idx, value);
		@(negedge clk);
	endtask

	// Writes all three registers once the block is idle. An acknowledgment
	// produces no output byte, so a drained scoreboard does not prove the
	// front part is empty; a short settling pause covers its queue.
	task automatic configure(logic [7:0] address, logic [7:0] ctrl_zero, logic [7:0] ctrl_one);
		drain_results();
		repeat (16) @(negedge clk);
		cfg_write(CFG_ADDRESS, address);
		cfg_write(CFG_CTRL_ZERO, ctrl_zero);
		cfg_write(CFG_CTRL_ONE, ctrl_one);
		cfg_if.valid <= 1'b0;
	endtask

	// Random frames of mostly short length, with the odd long one. Now and
	// then an acknowledgment with random, meaningless data and last bits is
	// slipped in, inside or between frames.
	task automatic run_random(int count, int gap_pct);
		int sent;
		int len;
		sent = 0;
		while (sent < count) begin
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 16) : $urandom_range(1, 5);
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(0, 11) == 0) begin
					send_item(OP_ACK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
					sent++;
				end
				send_item(OP_DATA, pick_byte(), i == len - 1);
				sent++;
				if ($urandom_range(0, 99) < gap_pct)
					idle_gap($urandom_range(1, 18));
			end
		end
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		item_if.valid     = 1'b0;
		item_if.op        = OP_DATA;
		item_if.data_byte = 8'h00;
		item_if.last      = 1'b0;
		cfg_if.valid      = 1'b0;
		cfg_if.index      = CFG_ADDRESS;
		cfg_if.data       = 8'h00;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part, registers at their reset values. A four-byte frame
		// carrying both escapes and the extremes of the byte range.
		send_item(OP_DATA, 8'h00, 1'b0);
		send_item(OP_DATA, FRAME_FLAG, 1'b0);
		send_item(OP_DATA, ESCAPE_BYTE, 1'b0);
		send_item(OP_DATA, 8'hFF, 1'b1);
		// A one-byte frame whose byte and check both need escaping: the longest
		// burst the block can produce.
		send_item(OP_DATA, FRAME_FLAG, 1'b1);
		// Acknowledgment carrying a flag byte and last: both must be ignored.
		send_item(OP_ACK, FRAME_FLAG, 1'b1);
		send_item(OP_DATA, ESCAPE_BYTE, 1'b1);
		// Acknowledgment arriving inside an open frame leaves its header alone.
		send_item(OP_DATA, 8'h55, 1'b0);
		send_item(OP_ACK, 8'h00, 1'b0);
		send_item(OP_DATA, 8'hAA, 1'b1);
		// Payload checks that come out as the flag and as the escape byte.
		send_item(OP_DATA, 8'h7C, 1'b0);
		send_item(OP_DATA, 8'h02, 1'b1);
		send_item(OP_DATA, 8'h80, 1'b0);
		send_item(OP_DATA, 8'hFD, 1'b1);

		// Header fields that look like the flag and the escape byte go out as
		// they are, never stuffed.
		configure(FRAME_FLAG, ESCAPE_BYTE, 8'h00);
		send_item(OP_DATA, 8'h01, 1'b1);
		send_item(OP_ACK, 8'hFF, 1'b0);
		send_item(OP_DATA, FRAME_FLAG, 1'b1);

		// Register write while a frame is open: the rest of that frame is
		// unaffected, the next header picks up the new values.
		send_item(OP_DATA, 8'h11, 1'b0);
		configure(8'hFF, 8'hFF, 8'hFF);
		send_item(OP_DATA, 8'h22, 1'b1);
		send_item(OP_DATA, 8'h33, 1'b1);

		// Random frames with all-zero registers and moderate stalls.
		configure(8'h00, 8'h00, 8'h00);
		rx_stall_pct = 15;
		run_random(50, 20);

		// The receiver holds off for a long stretch while the sender keeps
		// offering requests with no gaps, so the block fills and stalls its
		// input. Afterwards the sender waits until everything has drained.
		configure(8'hFF, FRAME_FLAG, ESCAPE_BYTE);
		rx_hold_cycles = 150;
		run_random(40, 0);
		drain_results();
		rx_stall_pct = 25;
		run_random(30, 30);

		configure(pick_byte(), pick_byte(), pick_byte());
		rx_stall_pct = 10;
		run_random(60, 10);

		// Final stretch at full rate on both sides.
		configure(pick_byte(), pick_byte(), pick_byte());
		rx_stall_pct = 0;
		run_random(70, 0);

		drain_results();
		repeat (30) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("info_frame_byte_stuffer_tb: PASS");
		else
			$display("info_frame_byte_stuffer_tb: FAIL");
		$finish;
	end

	// Watchdog, far beyond the slowest legal run.
	initial begin
		#5000000;
		$display("info_frame_byte_stuffer_tb: FAIL");
		$finish;
	end

endmodule
